@@ sv/mrc_pkg.sv @@
package mrc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_FOLDS_DEF = 4;

  localparam int VAL_W = 32;
  localparam int WIDE_W = 64;

  // live mode codes, count_mode shares 0..4
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_WRAP   = 3'd1;
  localparam logic [2:0] MODE_JUMP   = 3'd2;
  localparam logic [2:0] MODE_BOUNCE = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;
  localparam logic [2:0] MODE_HOLD   = 3'd5;

  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] STAT_NORMAL = 2'd0;
  localparam logic [1:0] STAT_AT_END = 2'd1;
  localparam logic [1:0] STAT_ERROR  = 2'd2;

  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_END   = 3'd1;
  localparam logic [2:0] REG_STEP  = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;

  typedef struct packed {
    logic                     out_of_range;
    logic signed [WIDE_W-1:0] x_fold;
    logic signed [WIDE_W-1:0] x_clamp;
    logic signed [VAL_W-1:0]  step_fold;
  } fold_res_t;

endpackage

@@ sv/mrc_fold_step.sv @@
module mrc_fold_step (
  input  logic signed [mrc_pkg::WIDE_W-1:0] x,
  input  logic signed [mrc_pkg::WIDE_W-1:0] lo,
  input  logic signed [mrc_pkg::WIDE_W-1:0] hi,
  input  logic signed [mrc_pkg::WIDE_W-1:0] span,
  input  logic        [2:0]                 mode,
  input  logic signed [mrc_pkg::VAL_W-1:0]  step,
  output mrc_pkg::fold_res_t                res
);
  import mrc_pkg::*;

  localparam logic signed [VAL_W-1:0] STEP_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] STEP_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                     below;
  logic                     above;
  logic signed [WIDE_W-1:0] edge_val;
  logic signed [WIDE_W-1:0] far_val;

  assign below    = x < lo;
  assign above    = x > hi;
  assign edge_val = below ? lo : hi;
  assign far_val  = below ? hi : lo;

  always_comb begin
    res.out_of_range = below | above;
    res.x_clamp      = edge_val;
    res.step_fold    = step;
    unique case (mode)
      MODE_WRAP:   res.x_fold = below ? (x + span) : (x - span);
      MODE_JUMP:   res.x_fold = far_val;
      MODE_BOUNCE: begin
        // reflect about the crossed limit, reverse the step with saturation
        res.x_fold    = (edge_val <<< 1) - x;
        res.step_fold = (step == STEP_MIN) ? STEP_MAX : -step;
      end
      default:     res.x_fold = edge_val;
    endcase
  end

endmodule

@@ sv/mode_range_counter.sv @@
// Fixed-point range counter (signed, FRAC_BITS fraction bits).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes start,
// end, step and mode; every write to one of these re-checks the setup and
// reloads the counter with the start value. Writes are taken only while
// the sequencer is idle. Input channel (in_valid/in_ready) carries opcode,
// step_scale and new_value; each beat yields exactly one result beat on
// the out_ channel. An advance multiplies step by scale into a register at
// accept, then runs the fold loop on a shared 64-bit add/compare unit, one
// fold per cycle. An item passes ST_EXEC, then ST_FOLD for an active
// advance, then ST_DONE, which loads the output register. An advance folds
// at most MAX_FOLDS times; if still out of range, it is clamped to the
// crossed limit and fold_overflow is set.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls with a result still held, the next item
// waits in ST_DONE until the output register frees up. Reset (synchronous,
// rst_n low) zeroes the state, setup, counter and out_valid: mode none,
// so results report error status and a zero count until configured.
module mode_range_counter #(
  parameter int FRAC_BITS = mrc_pkg::FRAC_BITS_DEF,
  parameter int MAX_FOLDS = mrc_pkg::MAX_FOLDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [2:0]                cfg_index,
  input  logic        [mrc_pkg::VAL_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic        [1:0]                in_opcode,
  input  logic signed [mrc_pkg::VAL_W-1:0] in_step_scale,
  input  logic signed [mrc_pkg::VAL_W-1:0] in_new_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [mrc_pkg::VAL_W-1:0] out_count_value,
  output logic signed [15:0]               out_count_whole,
  output logic        [1:0]                out_count_status,
  output logic                             out_fold_overflow
);
  import mrc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FOLDS + 1);
  localparam logic [VAL_W-1:0] FRAC_MASK = VAL_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [VAL_W:0] WHOLE_MAX = 33'sd32767;
  localparam logic signed [VAL_W:0] WHOLE_MIN = -33'sd32768;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FOLD, ST_DONE} state_t;

  state_t state_r;

  logic signed [VAL_W-1:0]  start_r, end_r, step_r;
  logic        [2:0]        mode_r;
  logic signed [VAL_W-1:0]  count_r, live_step_r;
  logic        [2:0]        live_mode_r;

  logic        [1:0]        op_r;
  logic signed [VAL_W-1:0]  nv_r;
  logic signed [WIDE_W-1:0] prod_r, x_r, lo_r, hi_r, span_r;
  logic        [CNT_W-1:0]  fold_cnt_r;
  logic                     over_r;

  logic signed [VAL_W-1:0]  out_value_r;
  logic signed [15:0]       out_whole_r;
  logic        [1:0]        out_status_r;
  logic                     out_over_r;
  logic                     out_valid_r;

  // candidate setup with the written register substituted
  logic signed [VAL_W-1:0]  s_c, e_c, st_c;
  logic        [2:0]        m_c;
  logic                     cfg_hit, setup_ok;
  logic        [2:0]        live_mode_nxt;

  logic                     in_fire, cfg_fire, adv_active, out_load;
  logic signed [VAL_W-1:0]  lo_c, hi_c;
  fold_res_t                fold;

  logic signed [VAL_W-1:0]  v_c, shifted_c;
  logic signed [VAL_W:0]    whole_c;
  logic signed [15:0]       whole_sat_c;
  logic        [1:0]        status_c;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    s_c     = start_r;
    e_c     = end_r;
    st_c    = step_r;
    m_c     = mode_r;
    cfg_hit = 1'b1;
    unique case (cfg_index)
      REG_START: s_c  = signed'(cfg_data);
      REG_END:   e_c  = signed'(cfg_data);
      REG_STEP:  st_c = signed'(cfg_data);
      REG_MODE:  m_c  = cfg_data[2:0];
      default:   cfg_hit = 1'b0;
    endcase
    setup_ok = (m_c != MODE_NONE) && (m_c <= MODE_STOP) && (st_c != '0) &&
               !((s_c < e_c) && (st_c < 0)) && !((s_c > e_c) && (st_c > 0));
    if (!setup_ok)      live_mode_nxt = MODE_NONE;
    else if (s_c != e_c) live_mode_nxt = m_c;
    else                live_mode_nxt = MODE_HOLD;
  end

  assign lo_c = (start_r < end_r) ? start_r : end_r;
  assign hi_c = (start_r < end_r) ? end_r : start_r;
  assign adv_active = (op_r == OP_ADVANCE) && (live_mode_r >= MODE_WRAP) &&
                      (live_mode_r <= MODE_STOP);

  mrc_fold_step u_fold (
    .x    (x_r),
    .lo   (lo_r),
    .hi   (hi_r),
    .span (span_r),
    .mode (live_mode_r),
    .step (live_step_r),
    .res  (fold)
  );

  // result fields from the settled counter
  always_comb begin
    v_c       = (live_mode_r == MODE_NONE) ? '0 : count_r;
    shifted_c = v_c >>> FRAC_BITS;
    // truncate toward zero: floor shift, bump negatives with a fraction
    whole_c   = (VAL_W+1)'(shifted_c) +
                (VAL_W+1)'(v_c[VAL_W-1] && ((v_c & FRAC_MASK) != '0));
    if (whole_c > WHOLE_MAX)      whole_sat_c = 16'sh7fff;
    else if (whole_c < WHOLE_MIN) whole_sat_c = -16'sh8000;
    else                          whole_sat_c = whole_c[15:0];
    if (live_mode_r == MODE_NONE) status_c = STAT_ERROR;
    else if (live_mode_r == MODE_STOP && count_r == end_r) status_c = STAT_AT_END;
    else status_c = STAT_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      step_r      <= '0;
      mode_r      <= MODE_NONE;
      count_r     <= '0;
      live_step_r <= '0;
      live_mode_r <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_fire && cfg_hit) begin
        start_r     <= s_c;
        end_r       <= e_c;
        step_r      <= st_c;
        mode_r      <= m_c;
        live_step_r <= st_c;
        count_r     <= s_c;
        live_mode_r <= live_mode_nxt;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r    <= in_opcode;
            nv_r    <= in_new_value;
            prod_r  <= in_step_scale * live_step_r;
            lo_r    <= WIDE_W'(lo_c);
            hi_r    <= WIDE_W'(hi_c);
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fold_cnt_r <= '0;
          over_r     <= 1'b0;
          span_r     <= hi_r - lo_r;
          if (adv_active) begin
            x_r     <= WIDE_W'(count_r) + (prod_r >>> FRAC_BITS);
            state_r <= ST_FOLD;
          end else begin
            if (op_r == OP_SET && WIDE_W'(nv_r) >= lo_r && WIDE_W'(nv_r) <= hi_r)
              count_r <= nv_r;
            else if (op_r == OP_RESTART && live_mode_r != MODE_NONE)
              count_r <= start_r;
            state_r <= ST_DONE;
          end
        end
        ST_FOLD: begin
          if (!fold.out_of_range) begin
            count_r <= x_r[VAL_W-1:0];
            state_r <= ST_DONE;
          end else if (fold_cnt_r == CNT_W'(MAX_FOLDS)) begin
            count_r <= fold.x_clamp[VAL_W-1:0];
            over_r  <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            x_r         <= fold.x_fold;
            live_step_r <= fold.step_fold;
            fold_cnt_r  <= fold_cnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_value_r  <= v_c;
            out_whole_r  <= whole_sat_c;
            out_status_r <= status_c;
            out_over_r   <= over_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_count_value   = out_value_r;
  assign out_count_whole   = out_whole_r;
  assign out_count_status  = out_status_r;
  assign out_fold_overflow = out_over_r;

endmodule
